/* rtl/wavp_pkg.sv */
`timescale 1ns / 1ps
package wavp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_BAD_ID = 3'd0;
  localparam logic [2:0] ERR_TRUNC  = 3'd1;
  localparam logic [2:0] ERR_SHORT  = 3'd2;
  localparam logic [2:0] ERR_NOFMT  = 3'd3;
  localparam logic [2:0] ERR_UNSUP  = 3'd4;
  localparam logic [2:0] ERR_ALIGN  = 3'd5;
  localparam logic [2:0] ERR_EMPTY  = 3'd6;

  // Register indexes on the configuration port
  localparam logic REG_DEFAULT_RATE = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

  localparam logic [15:0] DEFAULT_RATE_RESET = 16'd11025;
  localparam logic [15:0] MAX_LENGTH_RESET   = 16'd65535;

  // Four-character codes, little-endian as they arrive
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] PCM_BITS    = 16'd8;

  // At most this many leading bytes of an fmt chunk are looked at; the core reads only the first 16.
  localparam int unsigned FMT_CAPTURE_BYTES = 32;

  typedef struct packed {
    logic [15:0] default_rate;
    logic [15:0] max_length;
  } wavp_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sample;
    logic [31:0] sample_rate;
    logic [15:0] sample_count;
    logic        last_sample;
    logic [2:0]  error_code;
  } wavp_result_t;

endpackage

/* rtl/wavp_cfg_regs.sv */
`timescale 1ns / 1ps
module wavp_cfg_regs
  import wavp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output wavp_cfg_t   cfg
);

  logic [15:0] default_rate_r;
  logic [15:0] max_length_r;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_rate_r <= DEFAULT_RATE_RESET;
      max_length_r   <= MAX_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEFAULT_RATE: default_rate_r <= pwdata[15:0];
        REG_MAX_LENGTH:   max_length_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEFAULT_RATE: prdata = {16'd0, default_rate_r};
      REG_MAX_LENGTH:   prdata = {16'd0, max_length_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.default_rate = default_rate_r;
  assign cfg.max_length   = max_length_r;

endmodule

/* rtl/wavp_core.sv */
`timescale 1ns / 1ps
module wavp_core
  import wavp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         beat_fire,
  input  logic [7:0]   data_byte,
  input  logic         end_of_stream,
  input  wavp_cfg_t    cfg,
  output logic         res_have,
  output wavp_result_t res
);

  localparam logic [3:0] PH_RIFF = 4'd0;
  localparam logic [3:0] PH_CHDR = 4'd1;
  localparam logic [3:0] PH_FMT  = 4'd2;
  localparam logic [3:0] PH_SKIP = 4'd3;
  localparam logic [3:0] PH_PAD  = 4'd4;
  localparam logic [3:0] PH_DATA = 4'd5;
  localparam logic [3:0] PH_IDLE = 4'd6;

  logic [3:0]  phase_r,  phase_nxt;
  logic [31:0] bc_r,     bc_nxt;
  logic [31:0] cid_r,    cid_nxt;
  logic [31:0] clen_r,   clen_nxt;
  logic [15:0] tag_r,    tag_nxt;
  logic [15:0] chan_r,   chan_nxt;
  logic [31:0] rate_r,   rate_nxt;
  logic [15:0] align_r,  align_nxt;
  logic [15:0] bits_r,   bits_nxt;
  logic        fseen_r,  fseen_nxt;
  logic [15:0] left_r,   left_nxt;

  logic [31:0] bc_inc;
  logic [31:0] len_full;
  logic [31:0] clamp_len;
  logic        have;
  logic [1:0]  kind;
  logic [2:0]  err;
  logic        last;

  function automatic logic [31:0] put32(input logic [31:0] field, input logic [1:0] pos,
                                        input logic [7:0] b);
    if (pos == 2'd0) put32 = {24'd0, b};
    else             put32 = field | ({24'd0, b} << {pos, 3'b000});
  endfunction

  function automatic logic [15:0] put16(input logic [15:0] field, input logic pos,
                                        input logic [7:0] b);
    if (!pos) put16 = {8'd0, b};
    else      put16 = field | {b, 8'd0};
  endfunction

  assign bc_inc    = bc_r + 32'd1;
  // The data length is complete only once the last header byte is merged in.
  assign len_full  = put32(clen_r, 2'd3, data_byte);
  assign clamp_len = (len_full > {16'd0, cfg.max_length}) ? {16'd0, cfg.max_length} : len_full;

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    cid_nxt   = cid_r;
    clen_nxt  = clen_r;
    tag_nxt   = tag_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    align_nxt = align_r;
    bits_nxt  = bits_r;
    fseen_nxt = fseen_r;
    left_nxt  = left_r;
    have      = 1'b0;
    kind      = KIND_ERROR;
    err       = ERR_BAD_ID;
    last      = 1'b0;

    unique case (phase_r)
      PH_RIFF: begin
        if (bc_r < 32'd4)       cid_nxt  = put32(cid_r, bc_r[1:0], data_byte);
        else if (bc_r >= 32'd8) clen_nxt = put32(clen_r, bc_r[1:0], data_byte);
        if (bc_r == 32'd11) begin
          bc_nxt = 32'd0;
          if (cid_nxt != ID_RIFF || clen_nxt != ID_WAVE) begin
            have      = 1'b1;
            err       = ERR_BAD_ID;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_CHDR;
          end
        end else begin
          bc_nxt = bc_inc;
        end
      end
      PH_CHDR: begin
        if (bc_r < 32'd4) cid_nxt  = put32(cid_r, bc_r[1:0], data_byte);
        else              clen_nxt = put32(clen_r, bc_r[1:0], data_byte);
        if (bc_r == 32'd7) begin
          bc_nxt = 32'd0;
          if (cid_r == ID_FMT) begin
            if (clen_nxt < FMT_MIN_LEN) begin
              have      = 1'b1;
              err       = ERR_SHORT;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_FMT;
            end
          end else if (cid_r == ID_DATA) begin
            have      = 1'b1;
            phase_nxt = PH_IDLE;
            if (!fseen_r) begin
              err = ERR_NOFMT;
            end else if (tag_r != 16'd1 || chan_r != 16'd1 || bits_r != PCM_BITS) begin
              err = ERR_UNSUP;
            end else if (align_r == 16'd0) begin
              err = ERR_ALIGN;
            end else if (clamp_len == 32'd0) begin
              err = ERR_EMPTY;
            end else begin
              kind      = KIND_HEADER;
              left_nxt  = clamp_len[15:0];
              phase_nxt = PH_DATA;
            end
          end else if (clen_nxt == 32'd0) begin
            phase_nxt = PH_CHDR;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else begin
          bc_nxt = bc_inc;
        end
      end
      PH_FMT: begin
        if ((bc_r < 32'(FMT_CAPTURE_BYTES)) && (bc_r < 32'd16)) begin
          case (bc_r[3:0]) inside
            4'd0, 4'd1:             tag_nxt   = put16(tag_r, bc_r[0], data_byte);
            4'd2, 4'd3:             chan_nxt  = put16(chan_r, bc_r[0], data_byte);
            4'd4, 4'd5, 4'd6, 4'd7: rate_nxt  = put32(rate_r, bc_r[1:0], data_byte);
            4'd12, 4'd13:           align_nxt = put16(align_r, bc_r[0], data_byte);
            4'd14, 4'd15:           bits_nxt  = put16(bits_r, bc_r[0], data_byte);
            default: ;
          endcase
        end
        if (bc_inc == clen_r) begin
          fseen_nxt = 1'b1;
          bc_nxt    = 32'd0;
          phase_nxt = clen_r[0] ? PH_PAD : PH_CHDR;
        end else begin
          bc_nxt = bc_inc;
        end
      end
      PH_SKIP: begin
        if (bc_inc == clen_r) begin
          bc_nxt    = 32'd0;
          phase_nxt = clen_r[0] ? PH_PAD : PH_CHDR;
        end else begin
          bc_nxt = bc_inc;
        end
      end
      PH_PAD: begin
        bc_nxt    = 32'd0;
        phase_nxt = PH_CHDR;
      end
      PH_DATA: begin
        have = 1'b1;
        kind = KIND_SAMPLE;
        if (left_r <= 16'd1) begin
          last      = 1'b1;
          left_nxt  = 16'd0;
          phase_nxt = PH_IDLE;
        end else begin
          left_nxt = left_r - 16'd1;
        end
      end
      default: ;
    endcase

    if (end_of_stream) begin
      // An unfinished file ends in truncation unless this beat already failed.
      if (phase_nxt != PH_IDLE && !(have && kind == KIND_ERROR)) begin
        have = 1'b1;
        kind = KIND_ERROR;
        err  = ERR_TRUNC;
        last = 1'b0;
      end
      phase_nxt = PH_RIFF;
      bc_nxt    = 32'd0;
      cid_nxt   = 32'd0;
      clen_nxt  = 32'd0;
      tag_nxt   = 16'd0;
      chan_nxt  = 16'd0;
      rate_nxt  = 32'd0;
      align_nxt = 16'd0;
      bits_nxt  = 16'd0;
      fseen_nxt = 1'b0;
      left_nxt  = 16'd0;
    end
  end

  always_comb begin
    res_have         = have;
    res.kind         = kind;
    res.sample       = (kind == KIND_SAMPLE) ? data_byte : 8'd0;
    res.sample_rate  = 32'd0;
    res.sample_count = 16'd0;
    res.last_sample  = (kind == KIND_SAMPLE) ? last : 1'b0;
    res.error_code   = (kind == KIND_ERROR) ? err : 3'd0;
    if (kind == KIND_HEADER) begin
      res.sample_rate  = (rate_r != 32'd0) ? rate_r : {16'd0, cfg.default_rate};
      res.sample_count = clamp_len[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      bc_r    <= 32'd0;
      cid_r   <= 32'd0;
      clen_r  <= 32'd0;
      tag_r   <= 16'd0;
      chan_r  <= 16'd0;
      rate_r  <= 32'd0;
      align_r <= 16'd0;
      bits_r  <= 16'd0;
      fseen_r <= 1'b0;
      left_r  <= 16'd0;
    end else if (beat_fire) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      cid_r   <= cid_nxt;
      clen_r  <= clen_nxt;
      tag_r   <= tag_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      align_r <= align_nxt;
      bits_r  <= bits_nxt;
      fseen_r <= fseen_nxt;
      left_r  <= left_nxt;
    end
  end

  // The last beat of a file always rearms the parser.
  assert property (@(posedge clk) disable iff (!rst_n)
    (beat_fire && end_of_stream) |=> (phase_r == PH_RIFF && bc_r == 32'd0 && !fseen_r))
    else $error("parser did not rearm after end of stream");

  // While passing samples through there is always at least one left to send.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != 16'd0))
    else $error("data phase with no samples left");

  // Identifier phases never run past their header length.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_RIFF) |-> (bc_r < 32'd12)) and ((phase_r == PH_CHDR) |-> (bc_r < 32'd8)))
    else $error("header byte counter out of range");

  // An error result carries no sample, header or last flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_have && res.kind == KIND_ERROR) |->
      (res.sample == 8'd0 && res.sample_rate == 32'd0 && res.sample_count == 16'd0
       && !res.last_sample))
    else $error("error result with payload");

endmodule

/* rtl/wavp_out_stage.sv */
`timescale 1ns / 1ps
module wavp_out_stage
  import wavp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  wavp_result_t res,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         can_take,
  output wavp_result_t out_res
);

  logic         valid_r, valid_nxt;
  wavp_result_t res_r;

  // A new beat may enter when no result is held or the held result leaves in the same cycle.
  assign can_take = !valid_r || out_ready;

  always_comb begin
    if (load)           valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
    else                valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/wav_pcm8_mono_stream_parser.sv */
`timescale 1ns / 1ps
// Streaming WAV header parser for 8-bit mono PCM files.
// Input channel: one file byte per beat on in_data_byte, with in_end_of_stream
// set on the final byte of the file. Result channel: at most one result per
// input beat, either the header (rate and clamped sample count), one sample
// byte with out_last_sample on the final one, or an error code.
// Each result is written into the output register by the input beat that
// causes it and shows in the next cycle. Throughput: one byte per cycle while
// in_ready is high; every byte updates only small counters and captured fields
// in a single pass, and the output register is the only stage between the two channels.
// When the receiver stalls with a result held, in_ready drops until that
// result is taken; it rises again in the cycle out_ready returns.
// Reset clears the parser to the RIFF identifier phase and loads the
// registers with a default rate of 11025 and a maximum length of 65535.
// Every end-of-stream byte rearms the parser for the next file; the
// configuration registers keep their values. Write them over the APB port
// only while no beat is in flight.
module wav_pcm8_mono_stream_parser
  import wavp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_sample,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_sample_count,
  output logic        out_last_sample,
  output logic [2:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wavp_cfg_t    cfg;
  wavp_result_t core_res;
  wavp_result_t held_res;
  logic         core_have;
  logic         can_take;
  logic         beat_fire;

  assign in_ready  = can_take;
  assign beat_fire = in_valid && can_take;

  wavp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wavp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_fire     (beat_fire),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .cfg           (cfg),
    .res_have      (core_have),
    .res           (core_res)
  );

  wavp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (beat_fire && core_have),
    .res       (core_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_take  (can_take),
    .out_res   (held_res)
  );

  assign out_kind         = held_res.kind;
  assign out_sample       = held_res.sample;
  assign out_sample_rate  = held_res.sample_rate;
  assign out_sample_count = held_res.sample_count;
  assign out_last_sample  = held_res.last_sample;
  assign out_error_code   = held_res.error_code;

endmodule
